// ----- rtl/fwmt_pkg.sv -----
// Shared widths, register codes and helper functions of the message throttle.
package fwmt_pkg;

  localparam int unsigned MAX_USERS_DEF = 256;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED       = 3'd0,
    CFG_LINE_LIMIT    = 3'd1,
    CFG_WINDOW_SECS   = 3'd2,
    CFG_PER_USER_MODE = 3'd3,
    CFG_WINDOW_START  = 3'd4
  } cfg_idx_t;

  function automatic logic [TIME_W-1:0] sat_add_time(
    input logic [TIME_W-1:0] a,
    input logic [TIME_W-1:0] b
  );
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// ----- rtl/fwmt_if.sv -----
// Valid/ready channel interfaces for messages and throttle decisions.
interface fwmt_in_if
  import fwmt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_seconds;
  logic [ID_W-1:0]     sender_id;
  logic                sender_local;
  logic                exempt;

  modport source (output valid, output now_seconds, output sender_id,
                  output sender_local, output exempt, input ready);
  modport sink   (input valid, input now_seconds, input sender_id,
                  input sender_local, input exempt, output ready);
endinterface

interface fwmt_out_if;
  logic valid;
  logic ready;
  logic throttled;
  logic over_limit;

  modport source (output valid, output throttled, output over_limit, input ready);
  modport sink   (input valid, input throttled, input over_limit, output ready);
endinterface

// ----- rtl/fwmt_count_ram.sv -----
// Per-sender count memory with one write port and one registered read port.
module fwmt_count_ram
  import fwmt_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_USERS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/fixed_window_message_throttle_unit.sv -----
// Top level of the fixed-window message throttle for one channel.
//
//   Channel  Direction  Handshake     Contents
//   in_chan  input      valid/ready   now_seconds, sender_id, sender_local, exempt
//   out_chan output     valid/ready   throttled, over_limit
//   cfg_*    input      write enable  register index, 32-bit write data
//
// One transaction per cycle sustained while out_chan.ready is held high; a decision
// is presented once the update stage fires (the count memory is read at the accepting
// edge; the update stage then feeds the result register and waits while out_chan stalls).
// The per-sender count is one read-modify-write per message; a write to the
// entry being read is forwarded. Valid bits in flip-flops clear the table at reset,
// at window rollover and on writes of the window length or start. Reset is synchronous;
// the output register lets a new message enter while a decision waits to be taken.
module fixed_window_message_throttle_unit
  import fwmt_pkg::*;
#(
  parameter int unsigned MAX_USERS = MAX_USERS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fwmt_in_if.sink                in_chan,
  fwmt_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;

  // Configuration registers.
  logic               enabled_r;
  logic [COUNT_W-1:0] line_limit_r;
  logic [COUNT_W-1:0] window_secs_r;
  logic               per_user_r;
  logic [TIME_W-1:0]  window_start_r;

  // Counting state.
  logic [TIME_W-1:0]    deadline_r, deadline_nxt;
  logic [COUNT_W-1:0]   chan_count_r, chan_count_nxt;
  logic [MAX_USERS-1:0] user_valid_r, user_valid_nxt;

  // Update stage.
  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [AW-1:0]      s1_addr_r;
  logic               s1_in_range_r;
  logic               s1_local_r;
  logic               s1_exempt_r;
  logic               fwd_r;
  logic [COUNT_W-1:0] fwd_data_r;

  // Output register.
  logic out_valid_r;
  logic out_throttled_r;
  logic out_over_r;

  logic               in_acc;
  logic               s1_fire;
  logic [TIME_W-1:0]  in_id_ext;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] rd_eff;
  logic               active;
  logic               rollover;
  logic               count_user;
  logic [COUNT_W-1:0] user_old;
  logic [COUNT_W-1:0] user_new;
  logic [COUNT_W-1:0] chan_old;
  logic [COUNT_W-1:0] chan_new;
  logic               over;
  logic               ram_we;

  assign s1_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign in_id_ext = TIME_W'(in_chan.sender_id);
  assign in_addr   = in_id_ext[AW-1:0];
  assign in_range  = in_id_ext < TIME_W'(MAX_USERS);

  assign rd_eff   = fwd_r ? fwd_data_r : ram_rdata;
  assign active   = s1_fire && enabled_r && !s1_exempt_r;
  assign rollover = s1_now_r > deadline_r;

  assign count_user = per_user_r && s1_local_r && s1_in_range_r;
  assign user_old   = (rollover || !user_valid_r[s1_addr_r]) ? '0 : rd_eff;
  assign user_new   = bump_count(user_old);
  assign chan_old   = rollover ? '0 : chan_count_r;
  assign chan_new   = bump_count(chan_old);

  always_comb begin
    if (!enabled_r || s1_exempt_r) begin
      over = 1'b0;
    end else if (per_user_r) begin
      over = count_user && (user_new >= line_limit_r);
    end else begin
      over = chan_new >= line_limit_r;
    end
  end

  assign ram_we = active && count_user;

  always_comb begin
    deadline_nxt   = deadline_r;
    chan_count_nxt = chan_count_r;
    user_valid_nxt = user_valid_r;
    if (active) begin
      if (rollover) begin
        deadline_nxt   = sat_add_time(s1_now_r, TIME_W'(window_secs_r));
        chan_count_nxt = '0;
        user_valid_nxt = '0;
      end
      if (count_user) begin
        user_valid_nxt[s1_addr_r] = 1'b1;
      end else if (!per_user_r) begin
        chan_count_nxt = chan_new;
      end
    end
  end

  fwmt_count_ram #(
    .DEPTH (MAX_USERS),
    .AW    (AW)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (user_new),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Configuration and counting state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r      <= 1'b0;
      line_limit_r   <= COUNT_W'(2);
      window_secs_r  <= COUNT_W'(1);
      per_user_r     <= 1'b0;
      window_start_r <= '0;
      deadline_r     <= TIME_W'(1);
      chan_count_r   <= '0;
      user_valid_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ENABLED: begin
          enabled_r <= cfg_wdata[0];
        end
        CFG_LINE_LIMIT: begin
          line_limit_r <= cfg_wdata[COUNT_W-1:0];
        end
        CFG_WINDOW_SECS: begin
          window_secs_r <= cfg_wdata[COUNT_W-1:0];
          deadline_r    <= sat_add_time(window_start_r, TIME_W'(cfg_wdata[COUNT_W-1:0]));
          chan_count_r  <= '0;
          user_valid_r  <= '0;
        end
        CFG_PER_USER_MODE: begin
          per_user_r <= cfg_wdata[0];
        end
        CFG_WINDOW_START: begin
          window_start_r <= cfg_wdata[TIME_W-1:0];
          deadline_r     <= sat_add_time(cfg_wdata[TIME_W-1:0], TIME_W'(window_secs_r));
          chan_count_r   <= '0;
          user_valid_r   <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      deadline_r   <= deadline_nxt;
      chan_count_r <= chan_count_nxt;
      user_valid_r <= user_valid_nxt;
    end
  end

  // Update stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Update stage payload, with forwarding of a write to the entry being read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r      <= in_chan.now_seconds;
      s1_addr_r     <= in_addr;
      s1_in_range_r <= in_range;
      s1_local_r    <= in_chan.sender_local;
      s1_exempt_r   <= in_chan.exempt;
      fwd_r         <= ram_we && (s1_addr_r == in_addr);
      fwd_data_r    <= user_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_throttled_r <= over && s1_local_r;
      out_over_r      <= over;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.throttled  = out_throttled_r;
  assign out_chan.over_limit = out_over_r;

endmodule

// ----- tb/sv/tb_fixed_window_message_throttle_unit.sv -----
// Self-checking testbench for the fixed-window message throttle with a cycle-free predictor.
module tb_fixed_window_message_throttle_unit
  import fwmt_pkg::*;
;

  typedef struct packed {
    logic [TIME_W-1:0] now_seconds;
    logic [ID_W-1:0]   sender_id;
    logic              sender_local;
    logic              exempt;
  } message_t;

  typedef struct packed {
    logic throttled;
    logic over_limit;
  } decision_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_CHOKED, RX_PERIODIC} rx_pattern_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_SPARE = CFG_IDX_W'(CFG_WINDOW_START + 1);
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 170;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fwmt_in_if  in_if();
  fwmt_out_if out_if();

  fixed_window_message_throttle_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic              rl_enabled;
  logic [COUNT_W-1:0] rl_limit;
  logic [COUNT_W-1:0] rl_window;
  logic              rl_per_user;
  logic [TIME_W-1:0] rl_start;
  logic [TIME_W-1:0] rl_deadline;
  logic [COUNT_W-1:0] rl_chan_count;
  logic [COUNT_W-1:0] rl_user_count [MAX_USERS_DEF];
  logic              rl_user_seen [MAX_USERS_DEF];

  message_t  pending_msgs[$];
  decision_t expected_decisions[$];
  int unsigned msgs_queued = 0;
  int unsigned decisions_seen = 0;
  int unsigned fail_count = 0;

  function automatic logic [TIME_W-1:0] deadline_from(input logic [TIME_W-1:0] base);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W - COUNT_W + 1){1'b0}}, rl_window};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

  function automatic void clear_counts();
    rl_chan_count = '0;
    for (int i = 0; i < MAX_USERS_DEF; i++) begin
      rl_user_count[i] = '0;
      rl_user_seen[i]  = 1'b0;
    end
  endfunction

  function automatic void reload_window();
    clear_counts();
    rl_deadline = deadline_from(rl_start);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_ENABLED:       rl_enabled = v[0];
      CFG_LINE_LIMIT:    rl_limit = v[COUNT_W-1:0];
      CFG_WINDOW_SECS: begin
        rl_window = v[COUNT_W-1:0];
        reload_window();
      end
      CFG_PER_USER_MODE: rl_per_user = v[0];
      CFG_WINDOW_START: begin
        rl_start = v[TIME_W-1:0];
        reload_window();
      end
      default: ;
    endcase
  endfunction

  function automatic decision_t throttle_decide(input message_t m);
    decision_t d;
    logic [COUNT_W-1:0] c;
    logic over;
    over = 1'b0;
    if (rl_enabled && !m.exempt) begin
      if (m.now_seconds > rl_deadline) begin
        clear_counts();
        rl_deadline = deadline_from(m.now_seconds);
      end
      if (rl_per_user) begin
        if (m.sender_local && int'(m.sender_id) < MAX_USERS_DEF) begin
          c = rl_user_seen[m.sender_id] ? rl_user_count[m.sender_id] : '0;
          c = count_up(c);
          rl_user_count[m.sender_id] = c;
          rl_user_seen[m.sender_id]  = 1'b1;
          over = (c >= rl_limit);
        end
      end else begin
        rl_chan_count = count_up(rl_chan_count);
        over = (rl_chan_count >= rl_limit);
      end
    end
    d.throttled  = over && m.sender_local;
    d.over_limit = over;
    return d;
  endfunction

  function automatic void queue_msg(input logic [TIME_W-1:0] now, input logic [ID_W-1:0] id,
                                    input logic from_local, input logic is_exempt);
    message_t m;
    m.now_seconds  = now;
    m.sender_id    = id;
    m.sender_local = from_local;
    m.exempt       = is_exempt;
    pending_msgs.push_back(m);
    msgs_queued++;
  endfunction

  task automatic wait_drained();
    while (decisions_seen != msgs_queued) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      CFG_ENABLED, CFG_PER_USER_MODE: keep = CFG_DATA_W'(1);
      CFG_LINE_LIMIT, CFG_WINDOW_SECS: keep = CFG_DATA_W'(16'hFFFF);
      CFG_WINDOW_START:               keep = '1;
      default:                        keep = '0;
    endcase
    data = (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    apply_reg_write(idx, data);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  message_t    held_msg;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_decisions.push_back(throttle_decide(held_msg));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_msgs.size() != 0) begin
          held_msg = pending_msgs.pop_front();
          in_if.valid        <= 1'b1;
          in_if.now_seconds  <= held_msg.now_seconds;
          in_if.sender_id    <= held_msg.sender_id;
          in_if.sender_local <= held_msg.sender_local;
          in_if.exempt       <= held_msg.exempt;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  rx_pattern_t rx_pattern = RX_FREE;
  int unsigned rx_left = 0;
  logic [1:0]  rx_tick = '0;

  always @(posedge clk) begin : result_monitor
    decision_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_left    = $urandom_range(32, 400);
      end else begin
        rx_left--;
      end
      rx_tick = rx_tick + 2'd1;
      case (rx_pattern)
        RX_FREE:     out_if.ready <= 1'b1;
        RX_COIN:     out_if.ready <= 1'($urandom);
        RX_CHOKED:   out_if.ready <= ($urandom_range(0, 4) == 0);
        RX_PERIODIC: out_if.ready <= (rx_tick != 2'b11);
        default:     out_if.ready <= 1'b1;
      endcase
      if (out_if.valid && out_if.ready) begin
        decisions_seen++;
        if (expected_decisions.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual throttled=%0b over_limit=%0b",
                   $time, out_if.throttled, out_if.over_limit);
          fail_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (out_if.throttled !== want.throttled) begin
            $display("%0t: throttled mismatch, expected %0b, actual %0b",
                     $time, want.throttled, out_if.throttled);
            fail_count++;
          end
          if (out_if.over_limit !== want.over_limit) begin
            $display("%0t: over_limit mismatch, expected %0b, actual %0b",
                     $time, want.over_limit, out_if.over_limit);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #(64'd2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  start_v;
    logic [COUNT_W-1:0] lim_v;
    logic [COUNT_W-1:0] win_v;
    logic [ID_W-1:0]    id_base;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.now_seconds  = '0;
    in_if.sender_id    = '0;
    in_if.sender_local = 1'b0;
    in_if.exempt       = 1'b0;
    out_if.ready       = 1'b0;
    rl_enabled  = 1'b0;
    rl_limit    = COUNT_W'(2);
    rl_window   = COUNT_W'(1);
    rl_per_user = 1'b0;
    rl_start    = '0;
    reload_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: nothing counts.
    queue_msg(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
    queue_msg(32'd0, 8'd0, 1'b0, 1'b0);
    queue_msg(32'd5, 8'd3, 1'b1, 1'b0);
    wait_drained();

    write_reg(CFG_ENABLED, 32'd1);
    write_reg(CFG_LINE_LIMIT, 32'd3);
    write_reg(CFG_WINDOW_SECS, 32'd10);
    write_reg(CFG_PER_USER_MODE, 32'd0);
    write_reg(CFG_WINDOW_START, 32'd100);
    write_reg(CFG_IDX_FIRST_SPARE, $urandom);
    end_writes();
    queue_msg(32'd100, 8'd0, 1'b1, 1'b0);
    queue_msg(32'd101, 8'd1, 1'b0, 1'b0);
    queue_msg(32'd102, 8'd2, 1'b1, 1'b0);
    queue_msg(32'd103, 8'd3, 1'b0, 1'b0);
    queue_msg(32'd104, 8'd4, 1'b1, 1'b1);
    queue_msg(32'd111, 8'd5, 1'b1, 1'b0);
    queue_msg(32'd0, 8'd6, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd7, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd8, 1'b0, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd9, 1'b1, 1'b0);
    wait_drained();

    // Per-user counting resumes without a window reload.
    write_reg(CFG_PER_USER_MODE, 32'd1);
    end_writes();
    queue_msg(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd7, 1'b0, 1'b0);
    queue_msg(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1);
    wait_drained();

    write_reg(CFG_LINE_LIMIT, 32'd0);
    end_writes();
    queue_msg(32'd50, 8'd9, 1'b1, 1'b0);
    queue_msg(32'd50, 8'd9, 1'b0, 1'b0);
    wait_drained();

    write_reg(CFG_LINE_LIMIT, 32'd1);
    write_reg(CFG_WINDOW_SECS, 32'd0);
    end_writes();
    queue_msg(32'd100, 8'd1, 1'b1, 1'b0);
    queue_msg(32'd101, 8'd1, 1'b1, 1'b0);
    queue_msg(32'd101, 8'd1, 1'b1, 1'b0);
    wait_drained();

    write_reg(CFG_WINDOW_START, 32'hFFFF_FFF0);
    write_reg(CFG_WINDOW_SECS, 32'hFFFF);
    write_reg(CFG_PER_USER_MODE, 32'd0);
    end_writes();
    queue_msg(32'hFFFF_FFFF, 8'd2, 1'b1, 1'b0);
    queue_msg(32'd0, 8'd2, 1'b0, 1'b0);
    wait_drained();

    write_reg(CFG_ENABLED, 32'd0);
    end_writes();
    queue_msg(32'hFFFF_FFFF, 8'd3, 1'b1, 1'b0);
    wait_drained();

    t = 32'd0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       lim_v = COUNT_W'(0);
        1:       lim_v = COUNT_W'(1);
        2:       lim_v = '1;
        3:       lim_v = COUNT_W'($urandom);
        default: lim_v = COUNT_W'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       win_v = COUNT_W'(0);
        1:       win_v = COUNT_W'(1);
        2:       win_v = '1;
        3:       win_v = COUNT_W'($urandom);
        default: win_v = COUNT_W'($urandom_range(2, 20));
      endcase
      case ($urandom_range(0, 3))
        0:       start_v = $urandom;
        1:       start_v = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
        default: start_v = 32'($urandom_range(0, 1000));
      endcase
      id_base = ID_W'($urandom);
      write_reg(CFG_ENABLED, {31'd0, ($urandom_range(0, 9) != 0)});
      write_reg(CFG_LINE_LIMIT, {16'd0, lim_v});
      write_reg(CFG_PER_USER_MODE, {31'd0, 1'($urandom)});
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_WINDOW_SECS, {16'd0, win_v});
        write_reg(CFG_WINDOW_START, start_v);
        t = start_v + 32'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_FIRST_SPARE, (1 << CFG_IDX_W) - 1)),
                  $urandom);
      end
      end_writes();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_msg($urandom, ID_W'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          case ($urandom_range(0, 19))
            0:             t = t + 32'(rl_window) + 32'($urandom_range(1, 3));
            1, 2, 3, 4, 5: t = t + 32'd1;
            default: ;
          endcase
          queue_msg(t,
                    ($urandom_range(0, 4) != 0) ? id_base + ID_W'($urandom_range(0, 3))
                                                : ID_W'($urandom),
                    ($urandom_range(0, 4) != 0), ($urandom_range(0, 9) == 0));
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_decisions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
